// ===== rtl/core/fbpa_pkg.sv =====
// shared field widths and codes of the fixed block pool allocator
package fbpa_pkg;

  // widths of the request, response and configuration fields
  localparam int ADDRW  = 32;
  localparam int SIZEW  = 16;
  localparam int COUNTW = 11;
  localparam int STATW  = 2;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 32;

  // request kinds
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // response status codes
  localparam logic [STATW-1:0] ST_DONE      = 2'd0;
  localparam logic [STATW-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATW-1:0] ST_IGNORED   = 2'd2;
  localparam logic [STATW-1:0] ST_BADCFG    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_BASE  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SIZE  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_COUNT = 2'd2;

  // register reset values
  localparam logic [ADDRW-1:0]  BASE_RST  = 32'd4096;
  localparam logic [SIZEW-1:0]  SIZE_RST  = 16'd16;
  localparam logic [COUNTW-1:0] COUNT_RST = 11'd1024;

endpackage

// ===== rtl/core/fbpa_if.sv =====
// request and response channel interfaces of the block pool allocator
interface fbpa_req_if
  import fbpa_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [ADDRW-1:0] address;

  modport source (output valid, output cmd, output address, input ready);
  modport sink   (input valid, input cmd, input address, output ready);
endinterface

interface fbpa_rsp_if
  import fbpa_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [STATW-1:0] status;
  logic [ADDRW-1:0] block_address;

  modport source (output valid, output status, output block_address, input ready);
  modport sink   (input valid, input status, input block_address, output ready);
endinterface

// ===== rtl/core/fixed_block_pool_allocator.sv =====
// fixed-size block pool allocator with a linked free list in ram
//
// Requests come in on req (cmd 0 allocate, 1 free with a byte address) and
// each one gives exactly one response word on rsp (status, block_address).
// One request is in work at a time; req.ready is low while it runs.
// An allocate runs through S_ALLOC, where the link ram read and the index
// multiply are registered together, and S_ALLOC2, which adds the base.
// A free divides the offset by the block size in the bit-serial divider,
// one quotient bit per cycle over 32 bits.
// Requests answered early (bad configuration, empty pool, out of region) go
// straight from S_ALLOC or S_FCHK to S_DONE. The response sits in an output
// register; the block accepts the next request while it waits, and a
// finished result is held until rsp.ready. After reset and after a write to
// a configuration register a clearing pass rewrites the link ram, one entry
// per cycle, and req.ready stays low until it ends. Configuration is
// written through cfg_we_i, cfg_idx_i and cfg_data_i; the user must write
// it only while no request is in work, which the block does not enforce.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
#(
  parameter int MAX_BLOCKS = 1024,
  parameter int ALIGNMENT  = 16,
  parameter int ADDR_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fbpa_req_if.sink          req,
  fbpa_rsp_if.source        rsp,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i
);

  localparam int IW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int LW   = $clog2(MAX_BLOCKS + 1);
  localparam int CMPW = (LW > COUNTW) ? LW : COUNTW;
  localparam int TOTW = SIZEW + COUNTW;
  localparam int PW   = LW + SIZEW;
  localparam int EW   = ((ADDR_WIDTH > ADDRW) ? ADDR_WIDTH : ADDRW) + 1;
  localparam logic [EW-1:0] LIMIT = {{(EW-1){1'b0}}, 1'b1} << ADDR_WIDTH;
  localparam logic [LW-1:0] END_MARK = LW'(MAX_BLOCKS);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ALLOC  = 3'd1;
  localparam logic [2:0] S_ALLOC2 = 3'd2;
  localparam logic [2:0] S_FCHK   = 3'd3;
  localparam logic [2:0] S_FDIV   = 3'd4;
  localparam logic [2:0] S_FEND   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [ADDRW-1:0]  base_q;
  logic [SIZEW-1:0]  size_q;
  logic [COUNTW-1:0] count_q;
  logic              cfg_hit;
  logic              cfg_ok_q, cfg_ok_d;
  logic [TOTW-1:0]   total_q, total_d;
  logic [EW-1:0]     region_end;
  logic              clear_q;
  logic [IW-1:0]     clr_cnt_q;
  logic [LW-1:0]     clr_link;
  logic [LW-1:0]     head_q, head_d;
  logic [ADDRW-1:0]  addr_q;
  logic [ADDRW-1:0]  offset;
  logic [PW-1:0]     prod_q, prod_d;
  logic [STATW-1:0]  res_status_q, res_status_d;
  logic [ADDRW-1:0]  res_addr_q, res_addr_d;
  logic              out_valid_q;
  logic [STATW-1:0]  out_status_q;
  logic [ADDRW-1:0]  out_addr_q;
  logic              out_load;
  logic              div_start;
  logic              div_done;
  logic [ADDRW-1:0]  div_quo;
  logic [SIZEW-1:0]  div_rem;
  logic              fsm_we;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [LW-1:0]     mem_wdata;
  logic [LW-1:0]     mem_rdata;

  assign cfg_hit = cfg_we_i &&
                   (cfg_idx_i == REG_BASE || cfg_idx_i == REG_SIZE ||
                    cfg_idx_i == REG_COUNT);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_RST;
      size_q  <= SIZE_RST;
      count_q <= COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE:  base_q  <= cfg_data_i[ADDRW-1:0];
        REG_SIZE:  size_q  <= cfg_data_i[SIZEW-1:0];
        REG_COUNT: count_q <= cfg_data_i[COUNTW-1:0];
        default: ;
      endcase
    end
  end

  // pool size and validity; alignment is a power of two, so a mask test
  always_comb begin
    total_d    = TOTW'(size_q) * TOTW'(count_q);
    region_end = EW'(base_q) + EW'(total_d);
    cfg_ok_d   = (size_q != '0) &&
                 ((size_q & SIZEW'(ALIGNMENT - 1)) == '0) &&
                 (count_q != '0) &&
                 (CMPW'(count_q) <= CMPW'(MAX_BLOCKS)) &&
                 (region_end <= LIMIT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_ok_q <= 1'b0;
    end else begin
      cfg_ok_q <= cfg_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
  end

  // clearing pass: entry i links to i+1, the last pool block to the end mark
  assign clr_link = (CMPW'(clr_cnt_q) == CMPW'(count_q) - CMPW'(1)) ?
                    END_MARK : LW'(clr_cnt_q) + LW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_q   <= 1'b1;
      clr_cnt_q <= '0;
    end else if (cfg_hit) begin
      clear_q   <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clear_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == IW'(MAX_BLOCKS - 1)) begin
        clear_q <= 1'b0;
      end
    end
  end

  // link memory
  assign mem_we    = clear_q || fsm_we;
  assign mem_waddr = clear_q ? clr_cnt_q : div_quo[IW-1:0];
  assign mem_wdata = clear_q ? clr_link : head_q;

  fbpa_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (head_q[IW-1:0]),
    .rdata_o (mem_rdata)
  );

  // divider for free checks
  assign offset = addr_q - base_q;

  fbpa_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (offset),
    .divisor_i   (size_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign req.ready = (state_q == S_IDLE) && !clear_q;
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

  // request sequencer
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    prod_d       = prod_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    div_start    = 1'b0;
    fsm_we       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          state_d = (req.cmd == CMD_FREE) ? S_FCHK : S_ALLOC;
        end
      end
      S_ALLOC: begin
        res_addr_d = '0;
        prod_d     = PW'(head_q) * PW'(size_q);
        if (!cfg_ok_q) begin
          res_status_d = ST_BADCFG;
          state_d      = S_DONE;
        end else if (CMPW'(head_q) >= CMPW'(count_q)) begin
          res_status_d = ST_EXHAUSTED;
          state_d      = S_DONE;
        end else begin
          state_d = S_ALLOC2;
        end
      end
      S_ALLOC2: begin
        res_status_d = ST_DONE;
        res_addr_d   = base_q + ADDRW'(prod_q);
        head_d       = mem_rdata;
        state_d      = S_DONE;
      end
      S_FCHK: begin
        res_addr_d = '0;
        if (!cfg_ok_q) begin
          res_status_d = ST_BADCFG;
          state_d      = S_DONE;
        end else if (addr_q == '0 || addr_q < base_q ||
                     offset >= ADDRW'(total_q)) begin
          res_status_d = ST_IGNORED;
          state_d      = S_DONE;
        end else begin
          div_start = 1'b1;
          state_d   = S_FDIV;
        end
      end
      S_FDIV: begin
        if (div_done) begin
          state_d = S_FEND;
        end
      end
      S_FEND: begin
        if (div_rem != '0) begin
          res_status_d = ST_IGNORED;
        end else begin
          res_status_d = ST_DONE;
          fsm_we       = 1'b1;
          head_d       = LW'(div_quo);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= cfg_hit ? '0 : head_d;
    end
  end

  // request capture and result payload
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      addr_q <= req.address;
    end
    prod_q       <= prod_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
    end
  end

  // output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp.valid         = out_valid_q;
  assign rsp.status        = out_status_q;
  assign rsp.block_address = out_addr_q;

endmodule

// ===== rtl/core/fbpa_ram.sv =====
// generic simple dual port ram with registered read
module fbpa_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/fbpa_div.sv =====
// bit-serial restoring divider: block offset over block size, one bit a cycle
module fbpa_div
  import fbpa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ADDRW-1:0] dividend_i,
  input  logic [SIZEW-1:0] divisor_i,
  output logic             done_o,
  output logic [ADDRW-1:0] quotient_o,
  output logic [SIZEW-1:0] remainder_o
);

  localparam int CNTW = $clog2(ADDRW);

  logic             busy_q;
  logic             done_q;
  logic [CNTW-1:0]  cnt_q;
  logic [ADDRW-1:0] quo_q, quo_d;
  logic [SIZEW-1:0] rem_q, rem_d;
  logic [SIZEW-1:0] dsr_q;
  logic [SIZEW:0]   shifted;
  logic [SIZEW+1:0] diff;
  logic             fits;

  // one trial subtraction per cycle
  always_comb begin
    shifted = {rem_q, quo_q[ADDRW-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_q};
    fits    = ~diff[SIZEW+1];
    rem_d   = fits ? diff[SIZEW-1:0] : shifted[SIZEW-1:0];
    quo_d   = {quo_q[ADDRW-2:0], fits};
  end

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(ADDRW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// ===== verif/fixed_block_pool_allocator_tb.sv =====
// self-checking testbench of the fixed block pool allocator with a free-list shadow
module fixed_block_pool_allocator_tb
  import fbpa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_MAX   = 1024;
  localparam int ALIGN      = 16;
  localparam int CLK_PERIOD = 2;
  localparam int RUN_LIMIT  = 5_000_000;
  localparam int PHASES     = 22;

  localparam logic [COUNTW-1:0] END_MARK = COUNTW'(POOL_MAX);
  // index past the register list, written to check that it is ignored
  localparam logic [CFG_IW-1:0] REG_NONE = 2'd3;

  typedef struct {
    logic [STATW-1:0] status;
    logic [ADDRW-1:0] block_address;
  } pool_answer_t;

  // shadow of the free list and the pool layout, with the answers still owed
  class free_list_shadow;
    logic [COUNTW-1:0] link_mem [POOL_MAX];
    logic [COUNTW-1:0] head;
    logic [ADDRW-1:0]  base;
    logic [SIZEW-1:0]  bsize;
    logic [COUNTW-1:0] bcount;
    bit                pool_ok;
    pool_answer_t      answers_due [$];
    logic [ADDRW-1:0]  handed_out [$];
    int                errors = 0;

    function void load_defaults();
      base   = BASE_RST;
      bsize  = SIZE_RST;
      bcount = COUNT_RST;
      rebuild_list();
    endfunction

    function bit layout_valid();
      logic [63:0] span;
      span = 64'(bsize) * 64'(bcount);
      if (bsize == 0 || (bsize % ALIGN) != 0) return 1'b0;
      if (bcount == 0 || bcount > POOL_MAX) return 1'b0;
      if (span - 64'd1 > 64'hFFFF_FFFF - 64'(base)) return 1'b0;
      return 1'b1;
    endfunction

    // every block free again, in ascending order
    function void rebuild_list();
      int i;
      pool_ok = layout_valid();
      for (i = 0; i < POOL_MAX; i++) link_mem[i] = COUNTW'(i + 1);
      handed_out.delete();
      if (!pool_ok) begin
        head = END_MARK;
        return;
      end
      link_mem[bcount - 1] = END_MARK;
      head = '0;
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        REG_BASE:  base = data[ADDRW-1:0];
        REG_SIZE:  bsize = data[SIZEW-1:0];
        REG_COUNT: bcount = data[COUNTW-1:0];
        default:   return;
      endcase
      rebuild_list();
    endfunction

    // work out the answer to an accepted request word
    function void note_request(logic cmd, logic [ADDRW-1:0] addr);
      pool_answer_t ans;
      logic [63:0]  span;
      logic [63:0]  offset;
      logic [63:0]  idx;
      ans.status = ST_DONE;
      ans.block_address = '0;
      span = 64'(bsize) * 64'(bcount);
      if (!pool_ok) begin
        ans.status = ST_BADCFG;
      end else if (cmd == CMD_ALLOC) begin
        if (head >= END_MARK || head >= bcount) begin
          ans.status = ST_EXHAUSTED;
        end else begin
          ans.block_address = ADDRW'(64'(base) + 64'(head) * 64'(bsize));
          handed_out.push_back(ans.block_address);
          head = link_mem[head];
        end
      end else if (addr == 0 || addr < base) begin
        ans.status = ST_IGNORED;
      end else begin
        offset = 64'(addr) - 64'(base);
        if (offset >= span || (offset % 64'(bsize)) != 0) begin
          ans.status = ST_IGNORED;
        end else begin
          idx = offset / 64'(bsize);
          if (idx >= POOL_MAX) begin
            ans.status = ST_IGNORED;
          end else begin
            link_mem[idx] = head;
            head = COUNTW'(idx);
          end
        end
      end
      answers_due.push_back(ans);
    endfunction

    // compare a response word with the oldest answer owed
    function void check_response(logic [STATW-1:0] status, logic [ADDRW-1:0] addr);
      pool_answer_t want;
      if (answers_due.size() == 0) begin
        $display("%0t: response with nothing owed, status %0d address %h",
                 $time, status, addr);
        errors++;
        return;
      end
      want = answers_due.pop_front();
      if (status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, status);
        errors++;
      end
      if (addr !== want.block_address) begin
        $display("%0t: block_address mismatch, expected %h, actual %h",
                 $time, want.block_address, addr);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_data_i;

  fbpa_req_if req_ch ();
  fbpa_rsp_if rsp_ch ();

  free_list_shadow  pool = new();
  int               burst_left = 0;
  logic [ADDRW-1:0] last_freed = '0;
  int               hold_cnt = 0;
  int               stall_style = 0;
  int               style_age = 0;

  fixed_block_pool_allocator #(
    .MAX_BLOCKS(POOL_MAX),
    .ALIGNMENT (ALIGN),
    .ADDR_WIDTH(ADDRW)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // clock
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("fixed_block_pool_allocator_tb: done, errors");
    $finish;
  end

  // sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        pool.check_response(rsp_ch.status, rsp_ch.block_address);
      end
      if (req_ch.valid && req_ch.ready) begin
        pool.note_request(req_ch.cmd, req_ch.address);
      end
    end
  end

  // response stalls: the stall style is picked anew at random when style_age wraps
  always @(negedge clk_i) begin
    if (hold_cnt != 0) begin
      rsp_ch.ready = 1'b0;
      hold_cnt--;
    end else begin
      rsp_ch.ready = 1'b1;
      case (stall_style)
        1: if ($urandom_range(0, 2) == 0) hold_cnt = $urandom_range(1, 3);
        2: if ($urandom_range(0, 15) == 0) hold_cnt = $urandom_range(10, 50);
        default: hold_cnt = 0;
      endcase
    end
    style_age++;
    if (style_age == 300) begin
      style_age = 0;
      stall_style = $urandom_range(0, 2);
    end
  end

  // send one request word, in bursts with random gaps
  task automatic send_item(input logic cmd, input logic [ADDRW-1:0] addr);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 60);
      if (gap != 0) begin
        req_ch.valid = 1'b0;
        req_ch.cmd = 1'($urandom);
        req_ch.address = $urandom;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    req_ch.valid = 1'b1;
    req_ch.cmd = cmd;
    req_ch.address = addr;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  // stop sending and let every owed answer come back
  task automatic wait_drained();
    req_ch.valid = 1'b0;
    while (pool.answers_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // one register write, then wait out the list clearing pass
  task automatic write_register(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_data_i = $urandom;
    pool.write_reg(idx, data);
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic set_pool(input logic [ADDRW-1:0] b, input logic [SIZEW-1:0] sz,
                          input logic [COUNTW-1:0] cnt);
    wait_drained();
    write_register(REG_BASE, b);
    write_register(REG_SIZE, CFG_DW'(sz));
    write_register(REG_COUNT, CFG_DW'(cnt));
  endtask

  // address for a free: blocks in use in under half the picks, the rest other pool blocks, bad or doubled
  function automatic logic [ADDRW-1:0] pick_free_address();
    int unsigned pick;
    int unsigned k;
    logic [63:0] span;
    logic [63:0] blk;
    logic [63:0] a;
    pick = $urandom_range(0, 99);
    if (!pool.pool_ok) begin
      if (pick < 20) return '0;
      if (pick < 60) return pool.base + ADDRW'(16 * $urandom_range(0, 7));
      return $urandom;
    end
    span = 64'(pool.bsize) * 64'(pool.bcount);
    blk = 64'(pool.base) + 64'($urandom_range(0, pool.bcount - 1)) * 64'(pool.bsize);
    if (pick < 45 && pool.handed_out.size() > 0) begin
      k = $urandom_range(0, pool.handed_out.size() - 1);
      last_freed = pool.handed_out[k];
      pool.handed_out.delete(k);
      return last_freed;
    end
    if (pick < 58) begin
      a = blk;
    end else if (pick < 65) begin
      a = 64'(last_freed);
    end else if (pick < 72) begin
      a = blk + 64'($urandom_range(1, pool.bsize - 1));
    end else if (pick < 78) begin
      a = (pool.base == 0) ? 64'd0 :
          64'(pool.base) - 64'($urandom_range(1, (pool.base > 4096) ? 4096 : pool.base));
    end else if (pick < 84) begin
      a = 64'(pool.base) + span + 64'($urandom_range(0, 7)) * 64'(pool.bsize);
    end else if (pick < 88) begin
      a = 64'd0;
    end else if (pick < 94) begin
      // last block, or the first address past the region
      a = 64'(pool.base) + span - ($urandom_range(0, 1) ? 64'(pool.bsize) : 64'd0);
    end else begin
      a = 64'($urandom);
    end
    return a[ADDRW-1:0];
  endfunction

  // one layout, then a run of random requests against it
  task automatic run_pool_phase(input int kind, input bit poke_unused);
    int unsigned n_items;
    int unsigned alloc_pct;
    int unsigned i;
    logic [63:0] span;
    logic [ADDRW-1:0] b;
    logic [SIZEW-1:0] sz;
    logic [COUNTW-1:0] cnt;
    logic cmd;
    n_items = 100;
    case (kind)
      0: begin
        sz = SIZEW'(16 * $urandom_range(1, 4));
        cnt = COUNTW'($urandom_range(1, 12));
      end
      1: begin
        sz = 16'hFFF0;
        cnt = COUNTW'($urandom_range(1, 40));
      end
      2: begin
        sz = SIZEW'(16 * $urandom_range(1, 64));
        cnt = COUNTW'($urandom_range(1, 32));
      end
      3: begin
        sz = $urandom_range(0, 1) ? 16'd16 : SIZEW'(16 * $urandom_range(1, 4095));
        cnt = COUNTW'(POOL_MAX);
      end
      4: begin
        sz = SIZEW'(16 * $urandom_range(1, 8));
        cnt = COUNTW'($urandom_range(2, 20));
      end
      default: begin
        sz = SIZEW'(16 * $urandom_range(1, 256));
        cnt = COUNTW'($urandom_range(1, 64));
        n_items = 12;
      end
    endcase
    span = 64'(sz) * 64'(cnt);
    b = $urandom_range(0, 32'(64'h1_0000_0000 - span));
    if (kind == 2) b = ADDRW'(64'h1_0000_0000 - span);
    if (kind == 4) b = '0;
    // broken layouts
    if (kind == 5) begin
      case ($urandom_range(0, 4))
        0: sz = '0;
        1: sz = {16'($urandom) & 16'hFFF0} | SIZEW'($urandom_range(1, 15));
        2: cnt = '0;
        3: cnt = COUNTW'($urandom_range(POOL_MAX + 1, 2047));
        default: b = ADDRW'(64'h1_0000_0000 - span + 64'($urandom_range(1, 15)));
      endcase
    end
    set_pool(b, sz, cnt);
    alloc_pct = $urandom_range(30, 70);
    for (i = 0; i < n_items; i++) begin
      if (i % 25 == 24) alloc_pct = $urandom_range(20, 80);
      if (poke_unused && i == n_items / 2) begin
        wait_drained();
        write_register(REG_NONE, $urandom);
      end
      cmd = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
      send_item(cmd, (cmd == CMD_ALLOC) ? ADDRW'($urandom) : pick_free_address());
    end
  endtask

  // stimulus
  initial begin
    int phase;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_BASE;
    cfg_data_i = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_ALLOC;
    req_ch.address = '0;
    pool.load_defaults();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset layout: base 0x1000, 16-byte blocks, 1024 of them
    send_item(CMD_ALLOC, 32'hFFFF_FFFF);
    send_item(CMD_ALLOC, 32'h0000_0000);
    send_item(CMD_FREE, 32'h0000_0000);
    send_item(CMD_FREE, 32'h0000_0FF0);
    send_item(CMD_FREE, 32'h0000_1008);
    send_item(CMD_FREE, 32'h0000_5000);
    send_item(CMD_FREE, 32'hFFFF_FFFF);
    send_item(CMD_FREE, 32'h0000_1010);
    // double free goes on the list twice
    send_item(CMD_FREE, 32'h0000_1010);
    send_item(CMD_ALLOC, 32'h0000_0000);
    send_item(CMD_ALLOC, 32'h0000_0000);
    send_item(CMD_ALLOC, 32'h0000_0000);
    send_item(CMD_FREE, 32'h0000_4FF0);

    // single block at address zero: handed out, never taken back
    set_pool(32'h0, 16'd16, 11'd1);
    send_item(CMD_ALLOC, 32'h0);
    send_item(CMD_ALLOC, 32'h0);
    send_item(CMD_FREE, 32'h0);
    send_item(CMD_ALLOC, 32'h0);

    // region ending at the top of the address space
    set_pool(32'hFFFF_FFF0, 16'd16, 11'd1);
    send_item(CMD_ALLOC, 32'h0);
    send_item(CMD_FREE, 32'hFFFF_FFF0);
    send_item(CMD_ALLOC, 32'h0);

    // bad layouts answer everything with the config status
    set_pool(32'h0000_1000, 16'd0, 11'd4);
    send_item(CMD_ALLOC, 32'h0);
    send_item(CMD_FREE, 32'h0000_1000);
    set_pool(32'h0000_1000, 16'd24, 11'd4);
    send_item(CMD_ALLOC, 32'h0);
    set_pool(32'h0000_1000, 16'd16, 11'd1025);
    send_item(CMD_ALLOC, 32'h0);
    set_pool(32'hFFFF_FFF0, 16'd16, 11'd2);
    send_item(CMD_FREE, 32'hFFFF_FFF0);

    // random phases over many layouts
    for (phase = 0; phase < PHASES; phase++) begin
      run_pool_phase(phase % 6, phase == 8);
    end

    wait_drained();
    repeat (40) @(negedge clk_i);
    if (pool.errors == 0) begin
      $display("fixed_block_pool_allocator_tb: done, clean");
    end else begin
      $display("fixed_block_pool_allocator_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== fixed_block_pool_allocator.f =====
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_if.sv
rtl/core/fbpa_ram.sv
rtl/core/fbpa_div.sv
rtl/core/fixed_block_pool_allocator.sv
verif/fixed_block_pool_allocator_tb.sv
